// File: rtl/hnfp_pkg.sv
// ----------------------------------------------------------------------------
// hnfp_pkg: shared types and constants of the H.264 FU-A packetizer
// Holds the length width, the queue geometry and the job record that the
// front part hands to the back part.
// ----------------------------------------------------------------------------
package hnfp_pkg;

  localparam int LengthBits = 16;
  localparam int LimitBits  = 12;
  localparam int CmpBits    = (LengthBits > LimitBits) ? LengthBits : LimitBits;

  localparam logic [LimitBits-1:0] LimitReset = LimitBits'(1400);
  localparam logic [LimitBits-1:0] LimitFloor = LimitBits'(2);

  localparam logic [7:0] NriMask   = 8'h60;
  localparam logic [7:0] FuAType   = 8'h1C;
  localparam logic [7:0] TypeMask  = 8'h1F;
  localparam logic [7:0] StartBit  = 8'h80;
  localparam logic [7:0] EndBit    = 8'h40;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  // One job: either a single data byte, or FU indicator, FU header and data.
  typedef struct packed {
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        three;
    logic        data_first;
    logic        data_last;
    logic [15:0] seq;
  } job_t;

endpackage

// File: rtl/hnfp_front.sv
// ----------------------------------------------------------------------------
// hnfp_front: input classifier of the FU-A packetizer
// Tracks the position within the NAL unit, decides single packet or FU-A,
// counts fragment fill and sequence numbers; a job per byte but FU-A headers.
// ----------------------------------------------------------------------------
module hnfp_front import hnfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LimitBits-1:0] cfg_data_i,
  input  logic                 fire_i,
  input  logic [7:0]           nal_byte_i,
  input  logic [15:0]          nal_length_i,
  output logic                 push_o,
  output job_t                 job_o
);

  logic [LimitBits-1:0]  max_payload_q;
  logic [LengthBits-1:0] pos_q, pos_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [7:0]            hdr_q, hdr_d;
  logic [LimitBits-1:0]  fill_q, fill_d;
  logic                  frag_q, frag_d;
  logic [15:0]           seq_q, seq_d;

  logic [LimitBits-1:0]  lim;
  logic [LengthBits-1:0] len_in;
  logic                  pos_zero;
  logic                  last_byte;
  logic [LengthBits-1:0] remain;
  logic [LimitBits-1:0]  fill_inc;
  logic                  close;
  logic [7:0]            fuh;

  assign cfg_ready_o = 1'b1;
  assign lim = (max_payload_q < LimitFloor) ? LimitFloor : max_payload_q;
  assign len_in = LengthBits'(nal_length_i);
  assign pos_zero = (pos_q == '0);

  always_comb begin
    len_d  = len_q;
    hdr_d  = hdr_q;
    frag_d = frag_q;
    fill_d = fill_q;
    seq_d  = seq_q;
    push_o = 1'b0;
    close  = 1'b0;
    fuh    = '0;
    job_o  = '0;
    if (pos_zero) begin
      len_d  = (len_in == '0) ? LengthBits'(1) : len_in;
      hdr_d  = nal_byte_i;
      frag_d = CmpBits'(len_d) > CmpBits'(lim);
      fill_d = '0;
    end
    last_byte = ({1'b0, pos_q} + (LengthBits + 1)'(1)) >= {1'b0, len_d};
    remain    = len_d - pos_q;
    fill_inc  = fill_d + LimitBits'(1);

    job_o.data   = nal_byte_i;
    job_o.seq    = seq_q;
    job_o.fu_ind = (hdr_d & NriMask) | FuAType;
    if (!frag_d) begin
      push_o           = fire_i;
      job_o.data_first = pos_zero;
      job_o.data_last  = last_byte;
      if (fire_i && last_byte) begin
        seq_d = seq_q + 16'd1;
      end
    end else if (!pos_zero) begin
      fuh = hdr_d & TypeMask;
      if (pos_q == LengthBits'(1)) begin
        fuh = fuh | StartBit;
      end
      if (CmpBits'(remain) <= CmpBits'(lim)) begin
        fuh = fuh | EndBit;
      end
      close = last_byte || (fill_inc >= lim) || (fill_inc == '0);
      push_o           = fire_i;
      job_o.three      = (fill_d == '0);
      job_o.fu_hdr     = fuh;
      job_o.data_last  = close;
      fill_d = close ? '0 : fill_inc;
      if (fire_i && close) begin
        seq_d = seq_q + 16'd1;
      end
    end
    pos_d = last_byte ? '0 : pos_q + LengthBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= LimitReset;
      pos_q         <= '0;
      len_q         <= '0;
      hdr_q         <= '0;
      fill_q        <= '0;
      frag_q        <= 1'b0;
      seq_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_payload_q <= cfg_data_i;
      end
      if (fire_i) begin
        pos_q  <= pos_d;
        len_q  <= len_d;
        hdr_q  <= hdr_d;
        fill_q <= fill_d;
        frag_q <= frag_d;
        seq_q  <= seq_d;
      end
    end
  end

endmodule

// File: rtl/hnfp_queue.sv
// ----------------------------------------------------------------------------
// hnfp_queue: short job queue between front and back
// A small register FIFO that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module hnfp_queue import hnfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_data_o
);

  job_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCw-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o     = (count_q == QueueCw'(QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QueueCw'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QueueCw'(1);
      end
    end
  end

endmodule

// File: rtl/hnfp_back.sv
// ----------------------------------------------------------------------------
// hnfp_back: output sequencer of the FU-A packetizer
// Holds one job in its output register and sends its one or three bytes.
// ----------------------------------------------------------------------------
module hnfp_back import hnfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        q_data_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  payload_byte_o,
  output logic        packet_first_o,
  output logic        packet_last_o,
  output logic [15:0] sequence_number_o,
  output logic        last_of_run_o
);

  job_t       job_q;
  logic       vld_q;
  logic [1:0] idx_q;
  logic [1:0] last_idx;
  logic       out_fire, done, load;

  assign last_idx = job_q.three ? 2'd2 : 2'd0;
  assign out_fire = vld_q && ready_i;
  assign done     = out_fire && (idx_q == last_idx);
  assign load     = !vld_q || done;
  assign pop_o    = load && q_valid_i;

  always_comb begin
    unique case (idx_q)
      2'd0:    payload_byte_o = job_q.three ? job_q.fu_ind : job_q.data;
      2'd1:    payload_byte_o = job_q.fu_hdr;
      default: payload_byte_o = job_q.data;
    endcase
    packet_first_o = job_q.three ? (idx_q == 2'd0) : job_q.data_first;
    packet_last_o  = (idx_q == last_idx) && job_q.data_last;
    last_of_run_o  = (idx_q == last_idx);
  end

  assign valid_o           = vld_q;
  assign sequence_number_o = job_q.seq;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load) begin
      vld_q <= q_valid_i;
      idx_q <= '0;
    end else if (out_fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (idx_q <= last_idx))
    else $error("byte index beyond end of job");
  a_pop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0) && vld_q)
    else $error("new job does not start at its first byte");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !done) |-> !pop_o)
    else $error("job taken from queue while one is still being sent");
`endif

endmodule

// File: rtl/h264_nal_fua_packetizer.sv
// ----------------------------------------------------------------------------
// h264_nal_fua_packetizer: H.264 NAL unit to RTP payload (single / FU-A)
// Top level joining the input classifier, job queue and output sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one NAL unit byte per request, header byte first,
//   with the unit length beside it (sampled on the first byte only).
//   The master stream gives RTP payload bytes; tlast marks the last byte of
//   a packet, tuser carries the first-of-packet and last-of-input marks.
//   The config channel writes max_payload whenever it is valid (ready is
//   always high); write it only while the block is idle.
//   A job passes the job queue and then the output register before its first
//   byte appears. Throughput: one output byte per cycle while the receiver
//   is ready. Input requests are taken every cycle while the four-entry job
//   queue has room; a byte that opens an FU-A fragment gives three output
//   bytes; inputs also pause when prefixes pile up faster than output drains.
//   Reset clears position, fill and sequence counters and sets max_payload
//   to 1400. When the receiver stalls, the output byte holds, the queue
//   fills, and then slave tready drops.
// ----------------------------------------------------------------------------
module h264_nal_fua_packetizer import hnfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LimitBits-1:0] cfg_data_i,   // max_payload
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata, // [7:0] nal_byte, [23:8] nal_length
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata, // [7:0] payload_byte, [23:8] sequence_number
  output logic                 m_axis_tlast, // packet_last
  output logic [1:0]           m_axis_tuser  // [0] packet_first, [1] last_of_run
);

  logic        fire;
  logic        push, full, pop, q_valid;
  job_t        push_job, pop_job;
  logic [7:0]  payload_byte;
  logic [15:0] sequence_number;
  logic        packet_first, last_of_run;

  assign s_axis_tready = !full;
  assign fire = s_axis_tvalid && s_axis_tready;

  hnfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fire_i       (fire),
    .nal_byte_i   (s_axis_tdata[7:0]),
    .nal_length_i (s_axis_tdata[23:8]),
    .push_o       (push),
    .job_o        (push_job)
  );

  hnfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  hnfp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_data_i          (pop_job),
    .pop_o             (pop),
    .valid_o           (m_axis_tvalid),
    .ready_i           (m_axis_tready),
    .payload_byte_o    (payload_byte),
    .packet_first_o    (packet_first),
    .packet_last_o     (m_axis_tlast),
    .sequence_number_o (sequence_number),
    .last_of_run_o     (last_of_run)
  );

  assign m_axis_tdata = {sequence_number, payload_byte};
  assign m_axis_tuser = {last_of_run, packet_first};

endmodule
